@@ rtl/cst_pkg.sv @@
`timescale 1ns / 1ps

package cst_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  // operation codes
  localparam logic [2:0] OP_NEW       = 3'd0;
  localparam logic [2:0] OP_SET_STATE = 3'd1;
  localparam logic [2:0] OP_SET_PEER  = 3'd2;
  localparam logic [2:0] OP_SET_PROTO = 3'd3;
  localparam logic [2:0] OP_ADD_SENT  = 3'd4;
  localparam logic [2:0] OP_ADD_RECV  = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  localparam logic [1:0] CONN_CLOSED  = 2'd0;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  state;
    logic [1:0]  protocol;
    logic [63:0] peer;
    logic [63:0] sent;
    logic [63:0] received;
    logic [63:0] changed_ms;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_APPLY
  } fsm_t;

endpackage

@@ rtl/cst_entry_ram.sv @@
`timescale 1ns / 1ps

// One write port, one registered read port.
module cst_entry_ram #(
  parameter int unsigned ENTRIES = cst_pkg::ENTRIES_DEF
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] waddr,
  input  cst_pkg::entry_t                          wdata,
  input  logic                                     re,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] raddr,
  output cst_pkg::entry_t                          rdata
);

  cst_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/connection_stats_table.sv @@
`timescale 1ns / 1ps
// Flow: an id op is captured, searched in S_SCAN (no slot is read on an empty table), then
//   resolved in S_APPLY into the registered response; a read op goes through S_READ, then S_APPLY.
// A new request is taken only once the previous one has left S_APPLY; the search walks the
//   filled slots linearly through the read port of the entry RAM, one slot per cycle.
// Reset: clears the fill count and the handshake state; the RAM is not swept, slots at or
//   above the fill count read as zero and every slot is fully written when it is claimed.

module connection_stats_table #(
  parameter int unsigned ENTRIES = cst_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  op,
  input  logic [31:0] conn_id,
  input  logic [1:0]  new_state,
  input  logic [63:0] peer_token,
  input  logic [1:0]  protocol,
  input  logic [31:0] byte_count,
  input  logic [63:0] now_ms,
  input  logic [3:0]  read_index,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic        entry_used,
  output logic [31:0] entry_id,
  output logic [1:0]  entry_state,
  output logic [1:0]  entry_protocol,
  output logic [63:0] entry_peer,
  output logic [63:0] entry_sent,
  output logic [63:0] entry_received,
  output logic [63:0] entry_changed_ms
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;  // slot address
  localparam int unsigned CW = $clog2(ENTRIES + 1);                   // fill count

  cst_pkg::fsm_t state, state_next;

  logic [CW-1:0] fill_count;

  // captured request
  logic [2:0]  op_q;
  logic [31:0] id_q;
  logic [1:0]  nstate_q;
  logic [63:0] peer_q;
  logic [1:0]  proto_q;
  logic [31:0] count_q;
  logic [63:0] now_q;
  logic [3:0]  ridx_q;

  // search bookkeeping
  logic [CW-1:0] issue_addr;   // next slot to read
  logic          rd_pending;   // RAM data for cmp_addr arrives this cycle
  logic [AW-1:0] cmp_addr;
  logic          hit;
  logic [AW-1:0] hit_addr;
  logic          best_valid;   // oldest closed slot seen so far
  logic [AW-1:0] best_addr;
  logic [63:0]   best_time;

  // RAM ports
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  cst_pkg::entry_t ram_wdata, ram_rdata;

  logic accept, out_free, apply_go;
  logic match_now, scan_issue, scan_done;
  logic more_to_read, rd_in_fill, id_op;

  // apply-stage results
  logic [2:0]      st_res;
  logic [AW-1:0]   slot_res;
  logic            wr_res;
  logic [AW-1:0]   waddr_res;
  cst_pkg::entry_t wdata_res;
  cst_pkg::entry_t ent_res;
  logic            fill_inc;

  cst_entry_ram #(
    .ENTRIES (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_stall = (state != cst_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign apply_go  = (state == cst_pkg::S_APPLY) && out_free;

  // ops 0..5 with a nonzero id go through the search
  assign id_op = (op <= cst_pkg::OP_ADD_RECV) && (conn_id != 32'd0);

  assign more_to_read = (issue_addr < fill_count);
  // stop issuing reads on a hit so the matching entry stays in the RAM output register
  assign match_now  = (state == cst_pkg::S_SCAN) && rd_pending && (ram_rdata.id == id_q);
  assign scan_issue = (state == cst_pkg::S_SCAN) && !match_now && more_to_read;
  assign scan_done  = (state == cst_pkg::S_SCAN) && !rd_pending && !more_to_read;
  assign rd_in_fill = (32'(ridx_q) < 32'(fill_count));

  assign ram_re    = scan_issue || ((state == cst_pkg::S_READ) && rd_in_fill);
  assign ram_raddr = (state == cst_pkg::S_READ) ? AW'(ridx_q) : issue_addr[AW-1:0];
  assign ram_we    = apply_go && wr_res;
  assign ram_waddr = waddr_res;
  assign ram_wdata = wdata_res;

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cst_pkg::S_IDLE: begin
        if (accept) begin
          if (op == cst_pkg::OP_READ) begin
            state_next = cst_pkg::S_READ;
          end else if (id_op) begin
            state_next = cst_pkg::S_SCAN;
          end else begin
            state_next = cst_pkg::S_APPLY;
          end
        end
      end
      cst_pkg::S_SCAN: begin
        if (match_now || scan_done) begin
          state_next = cst_pkg::S_APPLY;
        end
      end
      cst_pkg::S_READ:  state_next = cst_pkg::S_APPLY;
      cst_pkg::S_APPLY: begin
        if (out_free) begin
          state_next = cst_pkg::S_IDLE;
        end
      end
      default: state_next = cst_pkg::S_IDLE;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op;
      id_q     <= conn_id;
      nstate_q <= new_state;
      peer_q   <= peer_token;
      proto_q  <= protocol;
      count_q  <= byte_count;
      now_q    <= now_ms;
      ridx_q   <= read_index;
    end
  end

  // search: one slot read per cycle, compared in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      hit        <= 1'b0;
      best_valid <= 1'b0;
      issue_addr <= '0;
    end else if (accept) begin
      rd_pending <= 1'b0;
      hit        <= 1'b0;
      best_valid <= 1'b0;
      issue_addr <= '0;
    end else if (state == cst_pkg::S_SCAN) begin
      rd_pending <= scan_issue;
      if (scan_issue) begin
        issue_addr <= issue_addr + CW'(1);
      end
      if (match_now) begin
        hit <= 1'b1;
      end else if (rd_pending && (ram_rdata.state == cst_pkg::CONN_CLOSED) &&
                   (!best_valid || (ram_rdata.changed_ms < best_time))) begin
        // strict compare keeps the lowest slot on a tie
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      cmp_addr <= issue_addr[AW-1:0];
    end
    if (match_now) begin
      hit_addr <= cmp_addr;
    end
    if ((state == cst_pkg::S_SCAN) && rd_pending && !match_now &&
        (ram_rdata.state == cst_pkg::CONN_CLOSED) &&
        (!best_valid || (ram_rdata.changed_ms < best_time))) begin
      best_addr <= cmp_addr;
      best_time <= ram_rdata.changed_ms;
    end
  end

  // apply: decide status, and for id ops modify the entry and write it back
  always_comb begin
    st_res    = cst_pkg::ST_IGNORED;
    slot_res  = '0;
    wr_res    = 1'b0;
    waddr_res = hit_addr;
    wdata_res = ram_rdata;
    ent_res   = '0;
    fill_inc  = 1'b0;
    if (op_q == cst_pkg::OP_READ) begin
      if (32'(ridx_q) < 32'(ENTRIES)) begin
        st_res   = cst_pkg::ST_OK;
        slot_res = AW'(ridx_q);
        if (rd_in_fill) begin
          ent_res = ram_rdata;
        end
      end
    end else if ((op_q <= cst_pkg::OP_ADD_RECV) && (id_q != 32'd0)) begin
      if (op_q == cst_pkg::OP_NEW) begin
        wdata_res    = '0;
        wdata_res.id = id_q;
        priority if (hit) begin
          st_res   = cst_pkg::ST_DUP;
          slot_res = hit_addr;
        end else if (32'(fill_count) < 32'(ENTRIES)) begin
          st_res    = cst_pkg::ST_OK;
          slot_res  = fill_count[AW-1:0];
          waddr_res = fill_count[AW-1:0];
          wr_res    = 1'b1;
          fill_inc  = 1'b1;
        end else if (best_valid) begin
          // recycle the closed connection with the oldest change time
          st_res    = cst_pkg::ST_OK;
          slot_res  = best_addr;
          waddr_res = best_addr;
          wr_res    = 1'b1;
        end else begin
          st_res = cst_pkg::ST_FULL;
        end
      end else if (!hit) begin
        st_res = cst_pkg::ST_NOTFOUND;
      end else begin
        st_res   = cst_pkg::ST_OK;
        slot_res = hit_addr;
        unique case (op_q)
          cst_pkg::OP_SET_STATE: begin
            wdata_res.state      = nstate_q;
            wdata_res.changed_ms = now_q;
            wr_res               = 1'b1;
          end
          cst_pkg::OP_SET_PEER: begin
            // peer is write-once
            if (ram_rdata.peer == 64'd0) begin
              wdata_res.peer = peer_q;
              wr_res         = 1'b1;
            end else begin
              st_res = cst_pkg::ST_IGNORED;
            end
          end
          cst_pkg::OP_SET_PROTO: begin
            wdata_res.protocol = proto_q;
            wr_res             = 1'b1;
          end
          default: begin
            // byte counters: zero or negative-looking counts are dropped
            if ((count_q == 32'd0) || count_q[31]) begin
              st_res = cst_pkg::ST_IGNORED;
            end else if (op_q == cst_pkg::OP_ADD_SENT) begin
              wdata_res.sent = ram_rdata.sent + {32'd0, count_q};
              wr_res         = 1'b1;
            end else begin
              wdata_res.received = ram_rdata.received + {32'd0, count_q};
              wr_res             = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (apply_go && fill_inc) begin
      fill_count <= fill_count + CW'(1);
    end
  end

  // response register: the next request is taken while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      status           <= st_res;
      slot             <= 4'(slot_res);
      entry_used       <= (ent_res.id != 32'd0);
      entry_id         <= ent_res.id;
      entry_state      <= ent_res.state;
      entry_protocol   <= ent_res.protocol;
      entry_peer       <= ent_res.peer;
      entry_sent       <= ent_res.sent;
      entry_received   <= ent_res.received;
      entry_changed_ms <= ent_res.changed_ms;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= 32'(ENTRIES))
    else $error("fill count beyond table size");

  a_fill_only_on_new: assert property (@(posedge clk) disable iff (rst)
    (fill_count != $past(fill_count)) |->
      ($past(state == cst_pkg::S_APPLY) && ($past(op_q) == cst_pkg::OP_NEW)))
    else $error("fill count moved outside a new-id transaction");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (rst)
    scan_issue |-> (issue_addr < fill_count))
    else $error("search read beyond filled slots");

  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == cst_pkg::S_APPLY))
    else $error("response raised without an apply cycle");

  a_no_write_while_busy_out: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == cst_pkg::S_APPLY) && !(rsp_valid && rsp_stall)))
    else $error("RAM written while response held");

endmodule
